### rtl/core/ascp_pkg.sv
// ascp_pkg: types, character constants and name tables for the slider command parser.
// Used by every module of the block; depends on nothing.
package ascp_pkg;

  localparam int NAME_COUNT = 10;
  localparam int ROOM_INDEX = 9;
  localparam int TAG_LEN    = 6;
  localparam int NAME_MAX   = 16;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_IDLE = 1'b1;

  localparam logic [1:0] ACT_NONE  = 2'd0;
  localparam logic [1:0] ACT_PARAM = 2'd1;
  localparam logic [1:0] ACT_ROOM  = 2'd2;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_OPEN  = 8'h5B;
  localparam logic [7:0] CH_CLOSE = 8'h5D;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [8*TAG_LEN-1:0] TAG_TEXT = "slider";

  localparam logic [8*NAME_MAX-1:0] NAME_TEXT [NAME_COUNT] = '{
    "Turn90", "Turn180", "TranslateTarget", "ObstacleDist", "ForwardEnc",
    "IRSpeed", "IRKp", "IRKi", "IRKd", "GoRoom"
  };

  localparam logic [4:0] NAME_LEN [NAME_COUNT] = '{
    5'd6, 5'd7, 5'd15, 5'd12, 5'd10, 5'd7, 5'd4, 5'd4, 5'd4, 5'd6
  };

  typedef enum logic [1:0] {
    PH_SEEK,
    PH_IN,
    PH_CLOSED,
    PH_DEAD
  } phase_t;

  typedef enum logic [1:0] {
    NP_SKIP,
    NP_SIGN,
    NP_DIGITS,
    NP_DONE
  } num_phase_t;

  typedef struct packed {
    logic [1:0]         action;
    logic [3:0]         param_select;
    logic signed [15:0] param_value;
    logic [3:0]         room_number;
  } res_t;

  // Character at position pos of the tag; valid for pos below TAG_LEN
  function automatic logic [7:0] tag_char(input logic [2:0] pos);
    logic [7:0] ch;
    ch = 8'h00;
    if (int'(pos) < TAG_LEN) begin
      ch = TAG_TEXT[8*(TAG_LEN-1-int'(pos)) +: 8];
    end
    return ch;
  endfunction

  // Character at position pos of name k; valid for pos below that name's length
  function automatic logic [7:0] name_char(input int k, input logic [3:0] pos);
    logic [7:0] ch;
    ch = 8'h00;
    if (int'(pos) < int'(NAME_LEN[k])) begin
      ch = NAME_TEXT[k][8*(int'(NAME_LEN[k])-1-int'(pos)) +: 8];
    end
    return ch;
  endfunction

endpackage

### rtl/core/ascp_if.sv
// ascp_if: valid/ready channel interfaces for received words and parse results.
// Depends on nothing.
interface ascp_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] data_byte;

  modport source (output valid, output op, output data_byte, input ready);
  modport sink (input valid, input op, input data_byte, output ready);
endinterface

interface ascp_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         action;
  logic [3:0]         param_select;
  logic signed [15:0] param_value;
  logic [3:0]         room_number;

  modport source (output valid, output action, output param_select, output param_value,
                  output room_number, input ready);
  modport sink (input valid, input action, input param_select, input param_value,
                input room_number, output ready);
endinterface

### rtl/core/ascp_parser.sv
// ascp_parser: per-frame bracket, token, name and number state, and the result of a frame.
// Depends on ascp_pkg.
module ascp_parser
  import ascp_pkg::*;
#(
  parameter int BUF_LEN = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       advance,
  input  logic       op,
  input  logic [7:0] data_byte,
  output res_t       res
);

  localparam int CNT_W = $clog2(BUF_LEN + 1);

  phase_t             phase_r, phase_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [1:0]         field_r, field_nxt;
  logic               tok_r, tok_nxt;
  logic [4:0]         pos_r, pos_nxt;
  logic               tag_r, tag_nxt;
  logic [NAME_COUNT-1:0] names_r, names_nxt;
  num_phase_t         np_r, np_nxt;
  logic               neg_r, neg_nxt;
  logic [15:0]        acc_r, acc_nxt;
  logic               vp_r, vp_nxt;

  logic       frame_end;
  logic       byte_ok;
  logic       pkt_en;
  logic       pkt_byte;
  logic       is_close;
  logic       is_comma;
  logic       tok_char;
  logic       tok_close;
  logic       is_space;
  logic       is_digit;
  logic [4:0] pos_eff;
  logic [15:0] value;
  logic [3:0]  sel_idx;
  logic        sel_hit;

  assign frame_end = advance && (op == OP_IDLE);
  assign byte_ok   = advance && (op == OP_BYTE) && (cnt_r != CNT_W'(BUF_LEN));
  assign is_close  = (data_byte == CH_CLOSE);
  assign is_comma  = (data_byte == CH_COMMA);
  assign is_space  = (data_byte == CH_SPACE) || ((data_byte >= CH_TAB) && (data_byte <= CH_CR));
  assign is_digit  = (data_byte >= CH_ZERO) && (data_byte <= CH_NINE);

  // bracket phase: next state
  always_comb begin
    phase_nxt = phase_r;
    if (frame_end) begin
      phase_nxt = PH_SEEK;
    end else if (byte_ok) begin
      if (data_byte == CH_NUL) begin
        if (phase_r != PH_CLOSED) begin
          phase_nxt = PH_DEAD;
        end
      end else begin
        case (phase_r)
          PH_SEEK: begin
            if (data_byte == CH_OPEN) begin
              phase_nxt = PH_IN;
            end else if (is_close) begin
              phase_nxt = PH_DEAD;
            end
          end
          PH_IN: begin
            if (is_close) begin
              phase_nxt = PH_CLOSED;
            end
          end
          default: phase_nxt = phase_r;
        endcase
      end
    end
  end

  // bracket phase: outputs
  always_comb begin
    case (phase_r)
      PH_IN:   pkt_en = 1'b1;
      default: pkt_en = 1'b0;
    endcase
  end

  assign pkt_byte  = byte_ok && pkt_en && (data_byte != CH_NUL);
  assign tok_char  = pkt_byte && !is_close && !is_comma;
  assign tok_close = pkt_byte && (is_close || is_comma) && tok_r;
  assign pos_eff   = tok_r ? pos_r : 5'd0;

  always_comb begin
    cnt_nxt   = cnt_r;
    field_nxt = field_r;
    tok_nxt   = tok_r;
    pos_nxt   = pos_r;
    tag_nxt   = tag_r;
    names_nxt = names_r;
    np_nxt    = np_r;
    neg_nxt   = neg_r;
    acc_nxt   = acc_r;
    vp_nxt    = vp_r;
    if (frame_end) begin
      cnt_nxt   = '0;
      field_nxt = 2'd0;
      tok_nxt   = 1'b0;
      pos_nxt   = 5'd0;
      tag_nxt   = 1'b1;
      names_nxt = '1;
      np_nxt    = NP_SKIP;
      neg_nxt   = 1'b0;
      acc_nxt   = 16'd0;
      vp_nxt    = 1'b0;
    end else begin
      if (byte_ok) begin
        cnt_nxt = cnt_r + CNT_W'(1);
      end
      if (tok_close) begin
        if (field_r == 2'd0) begin
          if (pos_r != 5'(TAG_LEN)) begin
            tag_nxt = 1'b0;
          end
        end else if (field_r == 2'd1) begin
          for (int k = 0; k < NAME_COUNT; k++) begin
            if (pos_r != NAME_LEN[k]) begin
              names_nxt[k] = 1'b0;
            end
          end
        end
        if (field_r != 2'd3) begin
          field_nxt = field_r + 2'd1;
        end
        tok_nxt = 1'b0;
      end
      if (tok_char) begin
        tok_nxt = 1'b1;
        if (field_r == 2'd0) begin
          if ((pos_eff >= 5'(TAG_LEN)) || (tag_char(pos_eff[2:0]) != data_byte)) begin
            tag_nxt = 1'b0;
          end
        end else if (field_r == 2'd1) begin
          for (int k = 0; k < NAME_COUNT; k++) begin
            if ((pos_eff >= NAME_LEN[k]) || (name_char(k, pos_eff[3:0]) != data_byte)) begin
              names_nxt[k] = 1'b0;
            end
          end
        end else if (field_r == 2'd2) begin
          vp_nxt = 1'b1;
          if ((np_r == NP_SKIP) && is_space) begin
            np_nxt = np_r;
          end else if ((np_r == NP_SKIP) && ((data_byte == CH_PLUS) ||
                                             (data_byte == CH_MINUS))) begin
            neg_nxt = (data_byte == CH_MINUS);
            np_nxt  = NP_SIGN;
          end else if ((np_r != NP_DONE) && is_digit) begin
            acc_nxt = (acc_r << 3) + (acc_r << 1) + 16'(data_byte - CH_ZERO);
            np_nxt  = NP_DIGITS;
          end else begin
            np_nxt = NP_DONE;
          end
        end
        pos_nxt = (pos_eff != 5'd31) ? pos_eff + 5'd1 : pos_eff;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SEEK;
      cnt_r   <= '0;
      field_r <= 2'd0;
      tok_r   <= 1'b0;
      pos_r   <= 5'd0;
      tag_r   <= 1'b1;
      names_r <= '1;
      np_r    <= NP_SKIP;
      neg_r   <= 1'b0;
      acc_r   <= 16'd0;
      vp_r    <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      field_r <= field_nxt;
      tok_r   <= tok_nxt;
      pos_r   <= pos_nxt;
      tag_r   <= tag_nxt;
      names_r <= names_nxt;
      np_r    <= np_nxt;
      neg_r   <= neg_nxt;
      acc_r   <= acc_nxt;
      vp_r    <= vp_nxt;
    end
  end

  // frame result: lowest surviving name wins
  assign value = neg_r ? (16'd0 - acc_r) : acc_r;

  always_comb begin
    sel_idx = 4'd0;
    sel_hit = 1'b0;
    for (int k = NAME_COUNT - 1; k >= 0; k--) begin
      if (names_r[k]) begin
        sel_idx = 4'(k);
        sel_hit = 1'b1;
      end
    end
  end

  always_comb begin
    res = '0;
    if ((phase_r == PH_CLOSED) && tag_r && vp_r && sel_hit) begin
      if (sel_idx == 4'(ROOM_INDEX)) begin
        if (value <= 16'd9) begin
          res.action      = ACT_ROOM;
          res.room_number = value[3:0];
        end
      end else begin
        res.action       = ACT_PARAM;
        res.param_select = sel_idx;
        res.param_value  = value;
      end
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(BUF_LEN))
    else $error("frame byte count beyond buffer length");

  a_frame_clear: assert property (@(posedge clk) disable iff (!rst_n)
    frame_end |=> (cnt_r == '0) && (phase_r == PH_SEEK) && !vp_r && tag_r)
    else $error("frame state not cleared after end of frame");

  a_value_field: assert property (@(posedge clk) disable iff (!rst_n)
    vp_r |-> (field_r >= 2'd2))
    else $error("value seen before the third token");

  a_room_range: assert property (@(posedge clk) disable iff (!rst_n)
    (res.action == ACT_ROOM) |-> (res.room_number <= 4'd9) && (res.param_value == 16'sd0))
    else $error("room request out of range");

endmodule

### rtl/core/ascp_result_reg.sv
// ascp_result_reg: output register of the result channel.
// Depends on ascp_pkg and ascp_out_if.
module ascp_result_reg
  import ascp_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  input  logic           load,
  input  res_t           res,
  output logic           out_free,
  ascp_out_if.source     out_ch
);

  logic valid_r, valid_nxt;
  res_t res_r, res_nxt;

  assign out_free = !valid_r || out_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    res_nxt   = res_r;
    if (load) begin
      valid_nxt = 1'b1;
      res_nxt   = res;
    end else if (out_ch.ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign out_ch.valid        = valid_r;
  assign out_ch.action       = res_r.action;
  assign out_ch.param_select = res_r.param_select;
  assign out_ch.param_value  = res_r.param_value;
  assign out_ch.room_number  = res_r.room_number;

endmodule

### rtl/core/ascii_slider_command_parser.sv
// ascii_slider_command_parser: top level, input register feeding the parser and result register.
// Depends on ascp_pkg, ascp_if, ascp_parser and ascp_result_reg.
//
// Usage: in_ch carries received words: op 0 is a byte in data_byte, op 1 marks line
// idle and closes the frame. Text between the frame's first '[' and first ']' is
// parsed as "slider,<name>,<number>"; only the first BUF_LEN bytes of a frame count.
// out_ch gives one result word per idle marker and none per byte: action 0 nothing,
// 1 parameter write (param_select, param_value), 2 room request (room_number).
// Throughput: one input word per cycle while no idle marker waits. An accepted word is
// held in the input register; an idle marker's result then passes through the result
// register to out_ch. Bytes never wait on out_ch; an idle marker waits in the
// input register while the result register is full and unread, and in_ch.ready drops
// until it moves on. Reset clears the frame state and empties both registers.
module ascii_slider_command_parser
  import ascp_pkg::*;
#(
  parameter int BUF_LEN = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  ascp_in_if.sink    in_ch,
  ascp_out_if.source out_ch
);

  logic       hold_valid_r, hold_valid_nxt;
  logic       hold_op_r, hold_op_nxt;
  logic [7:0] hold_byte_r, hold_byte_nxt;
  logic       advance;
  logic       out_free;
  logic       take;
  res_t       res;

  assign advance     = hold_valid_r && ((hold_op_r == OP_BYTE) || out_free);
  assign in_ch.ready = !hold_valid_r || advance;
  assign take        = in_ch.valid && in_ch.ready;

  always_comb begin
    hold_valid_nxt = hold_valid_r;
    hold_op_nxt    = hold_op_r;
    hold_byte_nxt  = hold_byte_r;
    if (take) begin
      hold_valid_nxt = 1'b1;
      hold_op_nxt    = in_ch.op;
      hold_byte_nxt  = in_ch.data_byte;
    end else if (advance) begin
      hold_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else begin
      hold_valid_r <= hold_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hold_op_r   <= hold_op_nxt;
    hold_byte_r <= hold_byte_nxt;
  end

  ascp_parser #(
    .BUF_LEN (BUF_LEN)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .advance   (advance),
    .op        (hold_op_r),
    .data_byte (hold_byte_r),
    .res       (res)
  );

  ascp_result_reg u_result (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (advance && (hold_op_r == OP_IDLE)),
    .res      (res),
    .out_free (out_free),
    .out_ch   (out_ch)
  );

  a_idle_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && (hold_op_r == OP_IDLE)) |=> out_ch.valid)
    else $error("end of frame gave no result word");

  a_byte_no_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (hold_valid_r && (hold_op_r == OP_BYTE)) |-> in_ch.ready)
    else $error("byte word stalled the input");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (hold_valid_r && !advance) |=> hold_valid_r && $stable(hold_op_r))
    else $error("stalled idle marker lost");

endmodule
